>>> design/dfrq_pkg.sv
`default_nettype none
package dfrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 104;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    localparam logic [2:0] OC_ADDED    = 3'd0;
    localparam logic [2:0] OC_DUP      = 3'd1;
    localparam logic [2:0] OC_FULL     = 3'd2;
    localparam logic [2:0] OC_REMOVED  = 3'd3;
    localparam logic [2:0] OC_NOTFOUND = 3'd4;
    localparam logic [2:0] OC_SCHEDULE = 3'd5;
    localparam logic [2:0] OC_IDLE     = 3'd6;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] addr;
        logic [KEY_WIDTH-1:0] param;
    } t_key;

    typedef struct packed {
        logic active;
        logic load;
        logic shift;
        logic hit_in;
    } t_cell_ctl;

    function automatic logic [KEY_WIDTH-1:0] to_key(input logic [31:0] d);
        logic [63:0] ext;
        ext = {32'b0, d};
        return ext[KEY_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] from_key(input logic [KEY_WIDTH-1:0] k);
        logic [63:0] ext;
        ext = 64'(k);
        return ext[31:0];
    endfunction

endpackage
`default_nettype wire

>>> design/dfrq_cell.sv
`default_nettype none
module dfrq_cell
    import dfrq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_key      i_req_key,
    input  wire t_key      i_next_key,
    output      t_key      o_key,
    output      logic      o_hit_chain
);

    t_key r_key;
    t_key n_key;
    logic w_match;

    assign w_match     = i_ctl.active && (r_key == i_req_key);
    assign o_hit_chain = i_ctl.hit_in | w_match;
    assign o_key       = r_key;

    // load at tail on add; on remove every cell at or past the hit takes its neighbor
    always_comb begin
        n_key = r_key;
        if (i_ctl.load) begin
            n_key = i_req_key;
        end else if (i_ctl.shift && o_hit_chain) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule
`default_nettype wire

>>> design/dedup_fifo_ready_queue_top.sv
`default_nettype none
// channel | dir | tdata (low bit up)                                    | tuser
// s_axis  | in  | action_addr 32, action_param 32, finish_status 1,     | func 2
//         |     | finish_value 32, zero pad 7                           |
// m_axis  | out | head_addr 32, head_param 32, status_out 1,            | outcome 3
//         |     | value_out 32, zero pad 7                              |
// Each request is captured in the IDLE state; then, in the EXEC state, every cell compares
// its key and the row loads the tail or shifts to close the gap (finish reads the head).
// One request at a time; the EXEC step waits while the output register is full and m_axis_tready is low.
// Synchronous active-low reset empties the queue; no clearing pass is needed.
module dedup_fifo_ready_queue_top
    import dfrq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output      logic              s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,  // action_addr, action_param, finish_status, finish_value
    input  wire logic [1:0]        s_axis_tuser,  // func
    output      logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output      logic [DATA_W-1:0] m_axis_tdata,  // head_addr, head_param, status_out, value_out
    output      logic [2:0]        m_axis_tuser   // outcome
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_m_valid;
    logic             n_m_valid;

    logic [1:0]  r_func;
    t_key        r_req_key;
    logic        r_status;
    logic [31:0] r_value;

    logic [2:0]  r_oc;
    logic [31:0] r_head_addr;
    logic [31:0] r_head_param;
    logic        r_status_out;
    logic [31:0] r_value_out;
    logic [2:0]  n_oc;
    logic [31:0] n_head_addr;
    logic [31:0] n_head_param;
    logic        n_status_out;
    logic [31:0] n_value_out;

    t_cell_ctl w_ctl   [QUEUE_DEPTH];
    t_key      w_key   [QUEUE_DEPTH];
    logic      w_chain [QUEUE_DEPTH];

    logic w_accept;
    logic w_commit;
    logic w_hit;
    logic w_full;
    logic w_add_ok;
    logic w_rem_ok;

    assign s_axis_tready = i_rst_n && (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_commit      = (r_state == ST_EXEC) && (!r_m_valid || m_axis_tready);
    assign w_hit         = w_chain[QUEUE_DEPTH-1];
    assign w_full        = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_add_ok      = w_commit && (r_func == FUNC_ADD) && !w_hit && !w_full;
    assign w_rem_ok      = w_commit && (r_func == FUNC_REMOVE) && w_hit;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            assign w_ctl[gi].active = (CNT_W'(gi) < r_count);
            assign w_ctl[gi].load   = w_add_ok && (CNT_W'(gi) == r_count);
            assign w_ctl[gi].shift  = w_rem_ok;
            if (gi == 0) begin : g_first
                assign w_ctl[gi].hit_in = 1'b0;
            end else begin : g_rest
                assign w_ctl[gi].hit_in = w_chain[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_last
                dfrq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (w_ctl[gi]),
                    .i_req_key   (r_req_key),
                    .i_next_key  (w_key[gi]),
                    .o_key       (w_key[gi]),
                    .o_hit_chain (w_chain[gi])
                );
            end else begin : g_mid
                dfrq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (w_ctl[gi]),
                    .i_req_key   (r_req_key),
                    .i_next_key  (w_key[gi+1]),
                    .o_key       (w_key[gi]),
                    .o_hit_chain (w_chain[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        n_oc         = OC_NOTFOUND;
        n_head_addr  = '0;
        n_head_param = '0;
        n_status_out = 1'b0;
        n_value_out  = '0;
        n_count      = r_count;
        unique case (r_func)
            FUNC_ADD: begin
                if (w_hit) begin
                    n_oc = OC_DUP;
                end else if (w_full) begin
                    n_oc = OC_FULL;
                end else begin
                    n_oc    = OC_ADDED;
                    n_count = r_count + CNT_W'(1);
                end
            end
            FUNC_REMOVE: begin
                if (w_hit) begin
                    n_oc    = OC_REMOVED;
                    n_count = r_count - CNT_W'(1);
                end
            end
            FUNC_FINISH: begin
                n_status_out = r_status;
                n_value_out  = r_value;
                if (r_count != '0) begin
                    n_oc         = OC_SCHEDULE;
                    n_head_addr  = from_key(w_key[0].addr);
                    n_head_param = from_key(w_key[0].param);
                end else begin
                    n_oc = OC_IDLE;
                end
            end
            default: begin
                n_oc = OC_NOTFOUND;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid;
        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        if (w_accept) begin
            n_state = ST_EXEC;
        end
        if (w_commit) begin
            n_state   = ST_IDLE;
            n_m_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            if (w_commit) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func          <= s_axis_tuser;
            r_req_key.addr  <= to_key(s_axis_tdata[31:0]);
            r_req_key.param <= to_key(s_axis_tdata[63:32]);
            r_status        <= s_axis_tdata[64];
            r_value         <= s_axis_tdata[96:65];
        end
        if (w_commit) begin
            r_oc         <= n_oc;
            r_head_addr  <= n_head_addr;
            r_head_param <= n_head_param;
            r_status_out <= n_status_out;
            r_value_out  <= n_value_out;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_oc;
    assign m_axis_tdata  = {7'b0, r_value_out, r_status_out, r_head_param, r_head_addr};

endmodule
`default_nettype wire
